// ===== hw/rtl/bto_pkg.sv =====
package bto_pkg;

  // triangle edges and box edges / corners
  localparam int unsigned NumTriEdges = 3;
  localparam int unsigned NumBoxEdges = 4;
  localparam int unsigned NumPairs    = NumTriEdges * NumBoxEdges;

  // cross product slots: den, ua numerator and ub numerator per edge pair,
  // then the triangle determinant and su / sv per box corner
  localparam int unsigned DenBase  = 0;
  localparam int unsigned NaBase   = NumPairs;
  localparam int unsigned NbBase   = 2 * NumPairs;
  localparam int unsigned DetIdx   = 3 * NumPairs;
  localparam int unsigned SuBase   = DetIdx + 1;
  localparam int unsigned SvBase   = SuBase + NumBoxEdges;
  localparam int unsigned NumCross = SvBase + NumBoxEdges;

  // pipeline depth from input transfer to result register
  localparam int unsigned NumStages = 4;

endpackage

// ===== hw/rtl/bto_if.sv =====
interface bto_in_if #(
  parameter int unsigned COORD_BITS = 20
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_min_x;
  logic [COORD_BITS-1:0] box_min_y;
  logic [COORD_BITS-1:0] box_max_x;
  logic [COORD_BITS-1:0] box_max_y;
  logic [COORD_BITS-1:0] vertex_a_x;
  logic [COORD_BITS-1:0] vertex_a_y;
  logic [COORD_BITS-1:0] vertex_b_x;
  logic [COORD_BITS-1:0] vertex_b_y;
  logic [COORD_BITS-1:0] vertex_c_x;
  logic [COORD_BITS-1:0] vertex_c_y;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y,
           vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
           vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    output ready
  );
endinterface

interface bto_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

// ===== hw/rtl/bto_front.sv =====
module bto_front #(
  parameter int unsigned COORD_BITS = 20,
  localparam int unsigned DW = COORD_BITS + 1
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [COORD_BITS-1:0] box_min_x_i,
  input  logic [COORD_BITS-1:0] box_min_y_i,
  input  logic [COORD_BITS-1:0] box_max_x_i,
  input  logic [COORD_BITS-1:0] box_max_y_i,
  input  logic [COORD_BITS-1:0] vertex_a_x_i,
  input  logic [COORD_BITS-1:0] vertex_a_y_i,
  input  logic [COORD_BITS-1:0] vertex_b_x_i,
  input  logic [COORD_BITS-1:0] vertex_b_y_i,
  input  logic [COORD_BITS-1:0] vertex_c_x_i,
  input  logic [COORD_BITS-1:0] vertex_c_y_i,
  output logic signed [DW-1:0]  ax_o [bto_pkg::NumCross],
  output logic signed [DW-1:0]  ay_o [bto_pkg::NumCross],
  output logic signed [DW-1:0]  bx_o [bto_pkg::NumCross],
  output logic signed [DW-1:0]  by_o [bto_pkg::NumCross],
  output logic                  vhit_o
);

  logic signed [DW-1:0] cx [bto_pkg::NumBoxEdges];
  logic signed [DW-1:0] cy [bto_pkg::NumBoxEdges];
  logic signed [DW-1:0] tx [bto_pkg::NumTriEdges];
  logic signed [DW-1:0] ty [bto_pkg::NumTriEdges];
  logic signed [DW-1:0] ax_d [bto_pkg::NumCross];
  logic signed [DW-1:0] ay_d [bto_pkg::NumCross];
  logic signed [DW-1:0] bx_d [bto_pkg::NumCross];
  logic signed [DW-1:0] by_d [bto_pkg::NumCross];
  logic signed [DW-1:0] ax_q [bto_pkg::NumCross];
  logic signed [DW-1:0] ay_q [bto_pkg::NumCross];
  logic signed [DW-1:0] bx_q [bto_pkg::NumCross];
  logic signed [DW-1:0] by_q [bto_pkg::NumCross];
  logic                 vhit_d;
  logic                 vhit_q;

  function automatic logic signed [DW-1:0] sx(input logic [COORD_BITS-1:0] v);
    return $signed({v[COORD_BITS-1], v});
  endfunction

  always_comb begin
    cx[0] = sx(box_min_x_i); cy[0] = sx(box_min_y_i);
    cx[1] = sx(box_max_x_i); cy[1] = sx(box_min_y_i);
    cx[2] = sx(box_max_x_i); cy[2] = sx(box_max_y_i);
    cx[3] = sx(box_min_x_i); cy[3] = sx(box_max_y_i);
    tx[0] = sx(vertex_a_x_i); ty[0] = sx(vertex_a_y_i);
    tx[1] = sx(vertex_b_x_i); ty[1] = sx(vertex_b_y_i);
    tx[2] = sx(vertex_c_x_i); ty[2] = sx(vertex_c_y_i);

    vhit_d = 1'b0;
    for (int i = 0; i < bto_pkg::NumTriEdges; i++) begin
      if (tx[i] > cx[0] && tx[i] < cx[2] && ty[i] > cy[0] && ty[i] < cy[2]) begin
        vhit_d = 1'b1;
      end
    end

    for (int i = 0; i < bto_pkg::NumTriEdges; i++) begin
      for (int j = 0; j < bto_pkg::NumBoxEdges; j++) begin
        automatic int n = (i == bto_pkg::NumTriEdges - 1) ? 0 : i + 1;
        automatic int k = (j == bto_pkg::NumBoxEdges - 1) ? 0 : j + 1;
        automatic int p = i * bto_pkg::NumBoxEdges + j;
        // da = box edge, db = triangle edge, e = box start - tri start
        ax_d[bto_pkg::DenBase + p] = DW'(cx[k] - cx[j]);
        ay_d[bto_pkg::DenBase + p] = DW'(cy[k] - cy[j]);
        bx_d[bto_pkg::DenBase + p] = DW'(tx[n] - tx[i]);
        by_d[bto_pkg::DenBase + p] = DW'(ty[n] - ty[i]);
        ax_d[bto_pkg::NaBase + p]  = DW'(tx[n] - tx[i]);
        ay_d[bto_pkg::NaBase + p]  = DW'(ty[n] - ty[i]);
        bx_d[bto_pkg::NaBase + p]  = DW'(cx[j] - tx[i]);
        by_d[bto_pkg::NaBase + p]  = DW'(cy[j] - ty[i]);
        ax_d[bto_pkg::NbBase + p]  = DW'(cx[k] - cx[j]);
        ay_d[bto_pkg::NbBase + p]  = DW'(cy[k] - cy[j]);
        bx_d[bto_pkg::NbBase + p]  = DW'(cx[j] - tx[i]);
        by_d[bto_pkg::NbBase + p]  = DW'(cy[j] - ty[i]);
      end
    end

    // v0 = C - A, v1 = B - A
    ax_d[bto_pkg::DetIdx] = DW'(tx[2] - tx[0]);
    ay_d[bto_pkg::DetIdx] = DW'(ty[2] - ty[0]);
    bx_d[bto_pkg::DetIdx] = DW'(tx[1] - tx[0]);
    by_d[bto_pkg::DetIdx] = DW'(ty[1] - ty[0]);
    for (int j = 0; j < bto_pkg::NumBoxEdges; j++) begin
      ax_d[bto_pkg::SuBase + j] = DW'(cx[j] - tx[0]);
      ay_d[bto_pkg::SuBase + j] = DW'(cy[j] - ty[0]);
      bx_d[bto_pkg::SuBase + j] = DW'(tx[1] - tx[0]);
      by_d[bto_pkg::SuBase + j] = DW'(ty[1] - ty[0]);
      ax_d[bto_pkg::SvBase + j] = DW'(tx[2] - tx[0]);
      ay_d[bto_pkg::SvBase + j] = DW'(ty[2] - ty[0]);
      bx_d[bto_pkg::SvBase + j] = DW'(cx[j] - tx[0]);
      by_d[bto_pkg::SvBase + j] = DW'(cy[j] - ty[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      bx_q   <= bx_d;
      by_q   <= by_d;
      vhit_q <= vhit_d;
    end
  end

  assign ax_o   = ax_q;
  assign ay_o   = ay_q;
  assign bx_o   = bx_q;
  assign by_o   = by_q;
  assign vhit_o = vhit_q;

endmodule

// ===== hw/rtl/bto_cross.sv =====
module bto_cross #(
  parameter int unsigned COORD_BITS = 20,
  localparam int unsigned DW = COORD_BITS + 1,
  localparam int unsigned PW = 2 * DW,
  localparam int unsigned XW = PW + 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] ax_i [bto_pkg::NumCross],
  input  logic signed [DW-1:0] ay_i [bto_pkg::NumCross],
  input  logic signed [DW-1:0] bx_i [bto_pkg::NumCross],
  input  logic signed [DW-1:0] by_i [bto_pkg::NumCross],
  input  logic                 tag_i,
  output logic signed [XW-1:0] x_o [bto_pkg::NumCross],
  output logic                 tag_o
);

  logic signed [PW-1:0] p1_q [bto_pkg::NumCross];
  logic signed [PW-1:0] p2_q [bto_pkg::NumCross];
  logic signed [XW-1:0] x_q  [bto_pkg::NumCross];
  logic                 tag1_q;
  logic                 tag2_q;

  // products, then difference
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < bto_pkg::NumCross; k++) begin
        p1_q[k] <= ax_i[k] * by_i[k];
        p2_q[k] <= ay_i[k] * bx_i[k];
        x_q[k]  <= $signed({p1_q[k][PW-1], p1_q[k]}) - $signed({p2_q[k][PW-1], p2_q[k]});
      end
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign x_o   = x_q;
  assign tag_o = tag2_q;

endmodule

// ===== hw/rtl/bto_judge.sv =====
module bto_judge #(
  parameter int unsigned COORD_BITS = 20,
  localparam int unsigned XW = 2 * (COORD_BITS + 1) + 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i [bto_pkg::NumCross],
  input  logic                 vhit_i,
  output logic                 hit_o
);

  logic signed [XW:0]   den;
  logic signed [XW:0]   na;
  logic signed [XW:0]   nb;
  logic signed [XW:0]   da;
  logic signed [XW:0]   db;
  logic signed [XW+1:0] det;
  logic signed [XW+1:0] su;
  logic signed [XW+1:0] sv;
  logic signed [XW+1:0] rest;
  logic                 ua_ok;
  logic                 ub_ok;
  logic                 hit_d;
  logic                 hit_q;

  always_comb begin
    den = '0; na = '0; nb = '0; da = '0; db = '0;
    su = '0; sv = '0; rest = '0; ua_ok = 1'b0; ub_ok = 1'b0;
    hit_d = vhit_i;
    // segment parameters inside [0,1], parallel edges excluded
    for (int p = 0; p < bto_pkg::NumPairs; p++) begin
      den = (XW+1)'(x_i[bto_pkg::DenBase + p]);
      na  = (XW+1)'(x_i[bto_pkg::NaBase + p]);
      nb  = (XW+1)'(x_i[bto_pkg::NbBase + p]);
      da  = na - den;
      db  = nb - den;
      if (den > 0) begin
        ua_ok = (na >= 0) && (da <= 0);
        ub_ok = (nb >= 0) && (db <= 0);
      end else begin
        ua_ok = (na <= 0) && (da >= 0);
        ub_ok = (nb <= 0) && (db >= 0);
      end
      if (den != 0 && ua_ok && ub_ok) begin
        hit_d = 1'b1;
      end
    end
    // box corner strictly inside the triangle
    det = (XW+2)'(x_i[bto_pkg::DetIdx]);
    for (int j = 0; j < bto_pkg::NumBoxEdges; j++) begin
      su   = (XW+2)'(x_i[bto_pkg::SuBase + j]);
      sv   = (XW+2)'(x_i[bto_pkg::SvBase + j]);
      rest = su + sv - det;
      if (det > 0 && su > 0 && sv > 0 && rest < 0) begin
        hit_d = 1'b1;
      end
      if (det < 0 && su < 0 && sv < 0 && rest > 0) begin
        hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

// ===== hw/rtl/box_triangle_overlap_test.sv =====
// Box / triangle overlap test. Each transfer on in_i carries one axis-aligned
// box and one triangle in signed fixed point (4 fraction bits); each produces
// exactly one transfer on out_o whose overlap bit is set when a triangle vertex
// is strictly inside the box, a box edge meets a triangle edge (segment
// parameters inclusive in [0,1], parallel edges never meet), or a box corner is
// strictly inside a non-degenerate triangle. All tests are exact integer cross
// products, no division. The pipeline takes one pair per cycle while no result
// is held on out_o; its stages are operand differences, products, cross
// differences, then sign compares into the result register. The whole pipeline
// advances together and freezes while a result waits on out_o, so nothing is
// lost or repeated under back-pressure.
module box_triangle_overlap_test #(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bto_in_if.sink        in_i,
  bto_out_if.source     out_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned XW = 2 * DW + 1;

  // stage valid bits, last one is the result register
  logic [bto_pkg::NumStages-1:0] valid_d;
  logic [bto_pkg::NumStages-1:0] valid_q;
  logic                          en;

  logic signed [DW-1:0] ax [bto_pkg::NumCross];
  logic signed [DW-1:0] ay [bto_pkg::NumCross];
  logic signed [DW-1:0] bx [bto_pkg::NumCross];
  logic signed [DW-1:0] by [bto_pkg::NumCross];
  logic signed [XW-1:0] xp [bto_pkg::NumCross];
  logic                 vhit_front;
  logic                 vhit_cross;
  logic                 hit;

  // move everything when the result slot is empty or being taken
  assign en         = !valid_q[bto_pkg::NumStages-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    valid_d = {valid_q[bto_pkg::NumStages-2:0], in_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // stage 1: sign extend, edge / corner deltas, vertex-in-box test
  bto_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i        (clk_i),
    .en_i         (en),
    .box_min_x_i  (in_i.box_min_x),
    .box_min_y_i  (in_i.box_min_y),
    .box_max_x_i  (in_i.box_max_x),
    .box_max_y_i  (in_i.box_max_y),
    .vertex_a_x_i (in_i.vertex_a_x),
    .vertex_a_y_i (in_i.vertex_a_y),
    .vertex_b_x_i (in_i.vertex_b_x),
    .vertex_b_y_i (in_i.vertex_b_y),
    .vertex_c_x_i (in_i.vertex_c_x),
    .vertex_c_y_i (in_i.vertex_c_y),
    .ax_o         (ax),
    .ay_o         (ay),
    .bx_o         (bx),
    .by_o         (by),
    .vhit_o       (vhit_front)
  );

  // stages 2 and 3: all cross products, one multiplier per term
  bto_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk_i (clk_i),
    .en_i  (en),
    .ax_i  (ax),
    .ay_i  (ay),
    .bx_i  (bx),
    .by_i  (by),
    .tag_i (vhit_front),
    .x_o   (xp),
    .tag_o (vhit_cross)
  );

  // stage 4: sign tests and final or
  bto_judge #(.COORD_BITS(COORD_BITS)) u_judge (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (xp),
    .vhit_i (vhit_cross),
    .hit_o  (hit)
  );

  assign out_o.valid   = valid_q[bto_pkg::NumStages-1];
  assign out_o.overlap = hit;

endmodule
